// File: sv/digram_index_table_macros.svh
// Assertion macros shared by the digram index table RTL.
// Depends on nothing; included by digram_index_table, the module that carries assertions.
`ifndef DIGRAM_INDEX_TABLE_MACROS_SVH
`define DIGRAM_INDEX_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DIT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DIT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/dit_pkg.sv
// Package for the digram index table: codes, token type and sizes.
// Depends on nothing; used by dit_cell and digram_index_table.
`default_nettype none

package dit_pkg;

  localparam int KEY_W           = 126;
  localparam int TABLE_DEPTH_DEF = 256;
  localparam int HANDLE_BITS_DEF = 16;

  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_DELETE = 2'd2;

  localparam logic [2:0] ST_MISS      = 3'd0;
  localparam logic [2:0] ST_HIT       = 3'd1;
  localparam logic [2:0] ST_INSERTED  = 3'd2;
  localparam logic [2:0] ST_PRESENT   = 3'd3;
  localparam logic [2:0] ST_NO_PAIR   = 3'd4;
  localparam logic [2:0] ST_DELETED   = 3'd5;
  localparam logic [2:0] ST_NOT_OWNER = 3'd6;
  localparam logic [2:0] ST_FULL      = 3'd7;

  // Operation broadcast to every cell while a search token walks the row.
  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } dit_op_t;

  // Control part of the search token handed from cell to cell.
  typedef struct packed {
    logic active;
    logic hit;
    logic owner;
    logic free_seen;
  } dit_tok_t;

endpackage

`default_nettype wire

// File: sv/digram_index_table.sv
// Digram index table for a grammar compressor: a row of entry cells searched by a
// token that steps one cell per clock. A request is taken when start is high and
// busy is low, and its single result beat appears on the out_ ports for exactly
// one cycle, marked by out_strobe; the receiver cannot stall, so it must take
// the beat in that cycle. Each request keeps the block busy while the token is
// launched, visits every cell in turn, one cell per cycle, and the result is
// registered. The table is empty right after reset (every valid bit clears at
// once), so no clearing pass is needed.
// Depends on dit_pkg, dit_cell and digram_index_table_macros.svh.
`default_nettype none

module digram_index_table #(
  parameter int TABLE_DEPTH = dit_pkg::TABLE_DEPTH_DEF,
  parameter int HANDLE_BITS = dit_pkg::HANDLE_BITS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [1:0]             in_req_type,
  input  wire logic signed [31:0]     in_first_value,
  input  wire logic [30:0]            in_first_exp,
  input  wire logic signed [31:0]     in_second_value,
  input  wire logic [30:0]            in_second_exp,
  input  wire logic                   in_second_present,
  input  wire logic [HANDLE_BITS-1:0] in_symbol_handle,
  output logic                        out_strobe,
  output logic [2:0]                  out_status,
  output logic [HANDLE_BITS-1:0]      out_found_handle
);
  import dit_pkg::*;

  `include "digram_index_table_macros.svh"

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   inject_r;
  logic [1:0]             req_r;
  logic                   pair_r;
  dit_op_t                op_r, op_nxt;
  logic [KEY_W-1:0]       key_r;
  logic [HANDLE_BITS-1:0] handle_r;
  logic                   strobe_r, strobe_nxt;
  logic [2:0]             status_r, status_nxt;
  logic [HANDLE_BITS-1:0] found_r, found_nxt;
  logic                   wr_en_r, wr_en_nxt;
  logic [IDX_W-1:0]       wr_idx_r;
  logic                   accept;

  // Token chain: entry 0 is fed by the controller, the last entry returns to it.
  dit_tok_t               tok_chain   [TABLE_DEPTH+1];
  logic [IDX_W-1:0]       free_chain  [TABLE_DEPTH+1];
  logic [HANDLE_BITS-1:0] found_chain [TABLE_DEPTH+1];
  dit_tok_t               tok_end;

  assign accept = start && (state_r == S_IDLE);
  assign busy   = (state_r != S_IDLE);

  // A fresh token starts with no hit, no free slot and a zero handle.
  always_comb begin
    tok_chain[0]        = '0;
    tok_chain[0].active = inject_r;
  end
  assign free_chain[0]  = '0;
  assign found_chain[0] = '0;
  assign tok_end        = tok_chain[TABLE_DEPTH];

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    dit_cell #(
      .HANDLE_BITS (HANDLE_BITS),
      .IDX_W       (IDX_W),
      .IDX         (g)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .op_i     (op_r),
      .key_i    (key_r),
      .handle_i (handle_r),
      .wr_en_i  (wr_en_r),
      .wr_idx_i (wr_idx_r),
      .tok_i    (tok_chain[g]),
      .free_i   (free_chain[g]),
      .found_i  (found_chain[g]),
      .tok_o    (tok_chain[g+1]),
      .free_o   (free_chain[g+1]),
      .found_o  (found_chain[g+1])
    );
  end

  // Map the request onto the cell operation. A delete or insert without a
  // second symbol leaves the table alone; an unknown request type does nothing.
  always_comb begin
    unique case (in_req_type)
      REQ_LOOKUP: op_nxt = OP_LOOKUP;
      REQ_INSERT: op_nxt = in_second_present ? OP_INSERT : OP_NONE;
      REQ_DELETE: op_nxt = in_second_present ? OP_DELETE : OP_NONE;
      default:    op_nxt = OP_NONE;
    endcase
  end

  // Once the token leaves the last cell the whole table has been seen, and the
  // result, plus the write for a successful insert, is settled here.
  always_comb begin
    state_nxt  = state_r;
    strobe_nxt = 1'b0;
    status_nxt = status_r;
    found_nxt  = found_r;
    wr_en_nxt  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (tok_end.active) begin
          state_nxt  = S_IDLE;
          strobe_nxt = 1'b1;
          status_nxt = ST_MISS;
          found_nxt  = '0;
          case (req_r)
            REQ_LOOKUP: begin
              if (tok_end.hit) begin
                status_nxt = ST_HIT;
                found_nxt  = found_chain[TABLE_DEPTH];
              end
            end
            REQ_INSERT: begin
              if (!pair_r) begin
                status_nxt = ST_NO_PAIR;
              end else if (tok_end.hit) begin
                status_nxt = ST_PRESENT;
              end else if (!tok_end.free_seen) begin
                status_nxt = ST_FULL;
              end else begin
                status_nxt = ST_INSERTED;
                wr_en_nxt  = 1'b1;
              end
            end
            REQ_DELETE: begin
              if (!pair_r) begin
                status_nxt = ST_NO_PAIR;
              end else if (tok_end.owner) begin
                status_nxt = ST_DELETED;
              end else begin
                status_nxt = ST_NOT_OWNER;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      inject_r <= 1'b0;
      strobe_r <= 1'b0;
      wr_en_r  <= 1'b0;
      op_r     <= OP_NONE;
    end else begin
      state_r  <= state_nxt;
      inject_r <= accept;
      strobe_r <= strobe_nxt;
      wr_en_r  <= wr_en_nxt;
      if (accept) begin
        op_r <= op_nxt;
      end
    end
    status_r <= status_nxt;
    found_r  <= found_nxt;
    // The slot index travels with the token; it is only used with wr_en_r.
    wr_idx_r <= free_chain[TABLE_DEPTH];
    if (accept) begin
      req_r    <= in_req_type;
      pair_r   <= in_second_present;
      key_r    <= {in_first_value, in_first_exp, in_second_value, in_second_exp};
      handle_r <= in_symbol_handle;
    end
  end

  assign out_strobe       = strobe_r;
  assign out_status       = status_r;
  assign out_found_handle = found_r;

  `DIT_ASSERT_NEXT(a_accept_launches, clk, rst_n, accept, inject_r && busy,
                   "accepted request did not launch a search token")
  `DIT_ASSERT_NOW(a_token_only_walking, clk, rst_n, tok_end.active, state_r == S_WALK,
                  "search token returned while no request was in progress")
  `DIT_ASSERT_NEXT(a_result_follows_token, clk, rst_n,
                   (state_r == S_WALK) && tok_end.active, out_strobe && !busy,
                   "result beat missing after the token left the last cell")
  `DIT_ASSERT_NOW(a_write_only_on_insert, clk, rst_n, wr_en_r,
                  out_strobe && (out_status == ST_INSERTED),
                  "table write without an inserted result beat")

endmodule

`default_nettype wire

// File: sv/dit_cell.sv
// One entry of the digram index table: stores a key, a handle and a valid bit,
// and updates the passing search token. Depends on dit_pkg.
`default_nettype none

module dit_cell #(
  parameter int HANDLE_BITS = dit_pkg::HANDLE_BITS_DEF,
  parameter int IDX_W       = 8,
  parameter int IDX         = 0
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire dit_pkg::dit_op_t          op_i,
  input  wire logic [dit_pkg::KEY_W-1:0] key_i,
  input  wire logic [HANDLE_BITS-1:0]    handle_i,
  input  wire logic                      wr_en_i,
  input  wire logic [IDX_W-1:0]          wr_idx_i,
  input  wire dit_pkg::dit_tok_t         tok_i,
  input  wire logic [IDX_W-1:0]          free_i,
  input  wire logic [HANDLE_BITS-1:0]    found_i,
  output dit_pkg::dit_tok_t              tok_o,
  output logic [IDX_W-1:0]               free_o,
  output logic [HANDLE_BITS-1:0]         found_o
);
  import dit_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic                   valid_r, valid_nxt;
  logic [KEY_W-1:0]       key_r;
  logic [HANDLE_BITS-1:0] handle_r;
  dit_tok_t               tok_r, tok_nxt;
  logic [IDX_W-1:0]       free_r, free_nxt;
  logic [HANDLE_BITS-1:0] found_r, found_nxt;
  logic                   match;
  logic                   wr_me;

  assign match = valid_r && (key_r == key_i);
  assign wr_me = wr_en_i && (wr_idx_i == MY_IDX);

  always_comb begin
    tok_nxt   = tok_i;
    free_nxt  = free_i;
    found_nxt = found_i;
    valid_nxt = valid_r;
    if (tok_i.active) begin
      case (op_i)
        OP_LOOKUP: begin
          if (match) begin
            tok_nxt.hit = 1'b1;
            found_nxt   = handle_r;
          end
        end
        OP_INSERT: begin
          if (match) begin
            tok_nxt.hit = 1'b1;
          end
          if (!valid_r && !tok_i.free_seen) begin
            tok_nxt.free_seen = 1'b1;
            free_nxt          = MY_IDX;
          end
        end
        OP_DELETE: begin
          // Keys are unique, so at most one cell can take the delete.
          if (match && (handle_r == handle_i)) begin
            tok_nxt.owner = 1'b1;
            valid_nxt     = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
    if (wr_me) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      tok_r   <= tok_nxt;
    end
    free_r  <= free_nxt;
    found_r <= found_nxt;
    if (wr_me) begin
      key_r    <= key_i;
      handle_r <= handle_i;
    end
  end

  assign tok_o   = tok_r;
  assign free_o  = free_r;
  assign found_o = found_r;

endmodule

`default_nettype wire

// File: tb/tb_digram_index_table.sv
`timescale 1ns / 1ps
// Self-checking testbench for digram_index_table: lookup, insert and delete requests are
// checked against a behavioural copy of the keyed store. Depends on dit_pkg and on
// digram_index_table with its cells; needs nothing else at run time.

module tb_digram_index_table;
  import dit_pkg::*;

  localparam int DEPTH        = TABLE_DEPTH_DEF;
  localparam int HBITS        = HANDLE_BITS_DEF;
  // Request type 3 has no name in the package; the block must treat it as a miss.
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;
  localparam int RANDOM_ITEMS = 480;
  localparam int FULL_TRIES   = 8;
  // Long enough for one request to walk the whole table, with a good margin.
  localparam int SETTLE_CYCLES = DEPTH + 50;

  // Keys are the four symbol fields packed as {first value, first exponent,
  // second value, second exponent}, 126 bits in all.
  localparam logic [KEY_W-1:0] KEY_EXTREME = {32'h8000_0000, 31'h7FFF_FFFF,
                                              32'h7FFF_FFFF, 31'h0};
  localparam logic [KEY_W-1:0] KEY_ONES    = '1;
  localparam logic [KEY_W-1:0] KEY_ZERO    = '0;

  typedef struct {
    logic [1:0]       req;
    logic [KEY_W-1:0] key;
    logic             pair;
    logic [HBITS-1:0] handle;
    int               gap;    // idle cycles before the beat is offered
    bit               drain;  // hold the beat back until every result is in
  } request_t;

  typedef struct {
    logic [2:0]       status;
    logic [HBITS-1:0] found;
  } outcome_t;

  typedef struct {
    logic [KEY_W-1:0] key;
    logic [HBITS-1:0] handle;
  } digram_t;

  logic                    clk               = 1'b0;
  logic                    rst_n             = 1'b0;
  logic                    start             = 1'b0;
  logic [1:0]              in_req_type       = '0;
  logic signed [31:0]      in_first_value    = '0;
  logic [30:0]             in_first_exp      = '0;
  logic signed [31:0]      in_second_value   = '0;
  logic [30:0]             in_second_exp     = '0;
  logic                    in_second_present = 1'b0;
  logic [HBITS-1:0]        in_symbol_handle  = '0;
  logic                    busy;
  logic                    out_strobe;
  logic [2:0]              out_status;
  logic [HBITS-1:0]        out_found_handle;

  request_t request_queue[$];     // beats still to be offered, in order
  outcome_t expected_outcomes[$]; // results predicted for accepted beats
  digram_t  digram_pool[$];       // keys the stimulus believes are stored
  int       error_count = 0;
  int       burst_left  = 0;

  // Behavioural copy of the store. Slots fill lowest first, as in the block,
  // although placement never shows at the outputs.
  bit               slot_valid  [DEPTH];
  logic [KEY_W-1:0] slot_key    [DEPTH];
  logic [HBITS-1:0] slot_handle [DEPTH];

  always #6 clk = ~clk;

  digram_index_table i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_req_type       (in_req_type),
    .in_first_value    (in_first_value),
    .in_first_exp      (in_first_exp),
    .in_second_value   (in_second_value),
    .in_second_exp     (in_second_exp),
    .in_second_present (in_second_present),
    .in_symbol_handle  (in_symbol_handle),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_found_handle  (out_found_handle)
  );

  // Applies one accepted request to the behavioural store and returns the
  // result the block must give for it.
  function automatic outcome_t digram_index_apply(request_t rq);
    outcome_t o;
    int       hit_slot;
    int       free_slot;
    o.status  = ST_MISS;
    o.found   = '0;
    hit_slot  = -1;
    free_slot = -1;
    for (int i = 0; i < DEPTH; i++) begin
      if (slot_valid[i] && slot_key[i] == rq.key && hit_slot < 0) hit_slot = i;
      if (!slot_valid[i] && free_slot < 0) free_slot = i;
    end
    case (rq.req)
      REQ_LOOKUP: begin
        // The pair flag plays no part in a lookup.
        if (hit_slot >= 0) begin
          o.status = ST_HIT;
          o.found  = slot_handle[hit_slot];
        end
      end
      REQ_INSERT: begin
        if (!rq.pair) o.status = ST_NO_PAIR;
        else if (hit_slot >= 0) o.status = ST_PRESENT;
        else if (free_slot < 0) o.status = ST_FULL;
        else begin
          slot_valid[free_slot]  = 1'b1;
          slot_key[free_slot]    = rq.key;
          slot_handle[free_slot] = rq.handle;
          o.status = ST_INSERTED;
        end
      end
      REQ_DELETE: begin
        // Only the owner of an entry may remove it.
        if (!rq.pair) o.status = ST_NO_PAIR;
        else if (hit_slot >= 0 && slot_handle[hit_slot] == rq.handle) begin
          slot_valid[hit_slot] = 1'b0;
          o.status = ST_DELETED;
        end else o.status = ST_NOT_OWNER;
      end
      default: ;
    endcase
    return o;
  endfunction

  // Appends a beat to the send queue. Most beats get a random gap, but now and
  // then a run of back-to-back beats starts.
  function automatic void queue_request(logic [1:0] req, logic [KEY_W-1:0] key,
                                        logic pair, logic [HBITS-1:0] handle, bit drain);
    request_t r;
    r.req    = req;
    r.key    = key;
    r.pair   = pair;
    r.handle = handle;
    r.drain  = drain;
    if (burst_left > 0) begin
      r.gap = 0;
      burst_left--;
    end else begin
      r.gap = $urandom_range(0, 11);
      if ($urandom_range(0, 19) == 0) burst_left = $urandom_range(10, 30);
    end
    request_queue.push_back(r);
  endfunction

  // A 32-bit field value, now and then one of the extremes.
  function automatic logic [31:0] symbol_word();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return '1;
      3:       return $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] fresh_key();
    logic [31:0] fv, fe, sv, se;
    fv = symbol_word();
    fe = symbol_word();
    sv = symbol_word();
    se = symbol_word();
    return {fv, fe[30:0], sv, se[30:0]};
  endfunction

  // The same digram with a single key bit flipped: it must never match.
  function automatic logic [KEY_W-1:0] near_miss(logic [KEY_W-1:0] key);
    logic [KEY_W-1:0] one_bit;
    one_bit = '0;
    one_bit[$urandom_range(0, KEY_W-1)] = 1'b1;
    return key ^ one_bit;
  endfunction

  function automatic int pool_find(logic [KEY_W-1:0] key);
    foreach (digram_pool[i]) if (digram_pool[i].key == key) return i;
    return -1;
  endfunction

  // Driver. A beat is taken at an edge where start is high and busy is low;
  // the prediction is made at that same edge, so it follows acceptance order.
  bit       beat_offered = 1'b0;  // start is high with the current beat
  bit       beat_loaded  = 1'b0;  // a beat has been taken from the send queue
  request_t current_beat;
  int       idle_left    = 0;

  always @(posedge clk) begin : drive
    bit launch;
    launch = 1'b0;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (beat_offered && !busy) begin
        expected_outcomes.push_back(digram_index_apply(current_beat));
        beat_offered = 1'b0;
        beat_loaded  = 1'b0;
      end
      if (!beat_loaded && request_queue.size() > 0) begin
        current_beat = request_queue.pop_front();
        beat_loaded  = 1'b1;
        idle_left    = current_beat.gap;
      end
      if (beat_offered) begin
        launch = 1'b1;
      end else if (beat_loaded) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (!(current_beat.drain && expected_outcomes.size() != 0)) begin
          launch            = 1'b1;
          beat_offered      = 1'b1;
          in_req_type       <= current_beat.req;
          in_first_value    <= current_beat.key[125:94];
          in_first_exp      <= current_beat.key[93:63];
          in_second_value   <= current_beat.key[62:31];
          in_second_exp     <= current_beat.key[30:0];
          in_second_present <= current_beat.pair;
          in_symbol_handle  <= current_beat.handle;
        end
      end
      // Written once per edge, so a beat that follows straight on keeps start high.
      start <= launch;
    end
  end

  // Monitor. A result beat lasts a single cycle and cannot be held off, so it
  // is compared at the edge that ends it.
  always @(posedge clk) begin : check
    outcome_t want;
    if (rst_n && out_strobe) begin
      if (expected_outcomes.size() == 0) begin
        $error("result beat with nothing outstanding: status %0d, handle %0h",
               out_status, out_found_handle);
        error_count++;
      end else begin
        want = expected_outcomes.pop_front();
        if (out_status !== want.status) begin
          $error("out_status: expected %0d, got %0d", want.status, out_status);
          error_count++;
        end
        if (out_found_handle !== want.found) begin
          $error("out_found_handle: expected %0h, got %0h", want.found, out_found_handle);
          error_count++;
        end
      end
    end
  end

  initial begin : stimulus
    int               n;
    int               idx;
    int               r;
    int               full_tries;
    bit               filling;
    bit               drain;
    logic [KEY_W-1:0] k;
    logic [HBITS-1:0] h;

    // Directed part: field extremes, every request type and the corner cases.
    queue_request(REQ_LOOKUP,  KEY_ZERO,    1'b0, '0,       1'b0); // empty store misses
    queue_request(REQ_INSERT,  KEY_EXTREME, 1'b1, 16'hFFFF, 1'b0);
    queue_request(REQ_LOOKUP,  KEY_EXTREME, 1'b0, '0,       1'b0); // pair flag ignored
    queue_request(REQ_INSERT,  KEY_EXTREME, 1'b1, 16'h1234, 1'b0); // already present
    queue_request(REQ_INSERT,  KEY_ONES,    1'b0, 16'h0001, 1'b0); // insert without pair
    queue_request(REQ_DELETE,  KEY_EXTREME, 1'b0, 16'hFFFF, 1'b0); // delete without pair
    queue_request(REQ_DELETE,  KEY_EXTREME, 1'b1, 16'h7FFF, 1'b0); // not the owner
    queue_request(REQ_DELETE,  KEY_ONES,    1'b1, 16'h0000, 1'b0); // absent key
    queue_request(REQ_UNKNOWN, KEY_EXTREME, 1'b1, 16'hFFFF, 1'b0); // unknown type
    queue_request(REQ_DELETE,  KEY_EXTREME, 1'b1, 16'hFFFF, 1'b1); // owner deletes
    queue_request(REQ_LOOKUP,  KEY_EXTREME, 1'b1, 16'hFFFF, 1'b0);
    queue_request(REQ_INSERT,  KEY_ONES,    1'b1, 16'h0000, 1'b0);
    queue_request(REQ_LOOKUP,  KEY_ONES,    1'b1, 16'hFFFF, 1'b0); // hit on handle zero
    queue_request(REQ_LOOKUP,  KEY_ONES ^ 126'd1, 1'b1, '0, 1'b0);
    queue_request(REQ_LOOKUP,  KEY_ONES ^ {1'b1, 125'd0}, 1'b1, '0, 1'b0);
    queue_request(REQ_INSERT,  KEY_ZERO,    1'b1, 16'h5A5A, 1'b0);
    queue_request(REQ_LOOKUP,  KEY_ZERO,    1'b0, 16'hA5A5, 1'b0);
    queue_request(REQ_DELETE,  KEY_ONES,    1'b1, 16'h0000, 1'b0);
    queue_request(REQ_DELETE,  KEY_ZERO,    1'b1, 16'h5A5A, 1'b0);

    // Random part. First the store is driven full with mostly fresh inserts and
    // a few further inserts are tried against the full store; after that the
    // mix turns towards lookups and deletes so entries are freed and reused.
    full_tries = 0;
    n          = 0;
    while (digram_pool.size() < DEPTH || full_tries < FULL_TRIES || n < RANDOM_ITEMS) begin
      filling = digram_pool.size() < DEPTH || full_tries < FULL_TRIES;
      drain   = $urandom_range(0, 29) == 0;
      r       = $urandom_range(0, 99);
      if (digram_pool.size() == 0) r = 0;
      idx     = digram_pool.size() > 0 ? $urandom_range(0, digram_pool.size() - 1) : 0;
      if (r < (filling ? 80 : 20)) begin
        k = fresh_key();
        h = HBITS'($urandom);
        queue_request(REQ_INSERT, k, 1'b1, h, drain);
        if (pool_find(k) < 0) begin
          if (digram_pool.size() < DEPTH) digram_pool.push_back('{k, h});
          else full_tries++;
        end
      end else if (r < (filling ? 84 : 26)) begin
        queue_request(REQ_INSERT, digram_pool[idx].key, 1'b1, HBITS'($urandom), drain);
      end else if (r < (filling ? 90 : 50)) begin
        queue_request(REQ_LOOKUP, digram_pool[idx].key, 1'($urandom_range(0, 1)),
                      HBITS'($urandom), drain);
      end else if (r < (filling ? 93 : 60)) begin
        queue_request(REQ_LOOKUP, near_miss(digram_pool[idx].key), 1'($urandom_range(0, 1)),
                      digram_pool[idx].handle, drain);
      end else if (r < (filling ? 96 : 84)) begin
        if ($urandom_range(0, 3) != 0) begin
          queue_request(REQ_DELETE, digram_pool[idx].key, 1'b1, digram_pool[idx].handle,
                        drain);
          digram_pool.delete(idx);
        end else begin
          h = digram_pool[idx].handle ^ (16'd1 << $urandom_range(0, HBITS - 1));
          queue_request(REQ_DELETE, digram_pool[idx].key, 1'b1, h, drain);
        end
      end else if (r < (filling ? 97 : 90)) begin
        queue_request(REQ_DELETE, near_miss(digram_pool[idx].key), 1'b1,
                      digram_pool[idx].handle, drain);
      end else begin
        // Noise: unknown type, or an insert or delete without a second symbol.
        case ($urandom_range(0, 2))
          0:       queue_request(REQ_UNKNOWN, fresh_key(), 1'($urandom_range(0, 1)),
                                 HBITS'($urandom), drain);
          1:       queue_request(REQ_INSERT, fresh_key(), 1'b0, HBITS'($urandom), drain);
          default: queue_request(REQ_DELETE, digram_pool[idx].key, 1'b0,
                                 digram_pool[idx].handle, drain);
        endcase
      end
      n++;
    end

    // Reset is held at the start and released once.
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (request_queue.size() != 0 || beat_loaded || expected_outcomes.size() != 0)
      @(posedge clk);
    // Let the block finish any request still in flight before judging.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: several times the slowest correct run.
  initial begin : watchdog
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
